>>> src/ptst_pkg.sv
`timescale 1ns / 1ps
package ptst_pkg;
   localparam int TableDepth = 16;
   localparam int IdxW = $clog2(TableDepth);
   localparam int CntW = $clog2(TableDepth + 1);
   localparam logic [7:0] AgeLimitReset = 8'd10;
   localparam logic [7:0] SweepIntervalReset = 8'd10;

   localparam logic [0:0] CsrAgeLimit = 1'b0;
   localparam logic [0:0] CsrSweepInterval = 1'b1;

   localparam logic OpRecord = 1'b0;
   localparam logic OpStatus = 1'b1;

   localparam logic [1:0] StStored = 2'd0;
   localparam logic [1:0] StFound = 2'd1;
   localparam logic [1:0] StNotFound = 2'd2;
   localparam logic [1:0] StFull = 2'd3;

   typedef struct packed {
      logic [15:0] frame_id;
      logic [31:0] packet_id;
      logic [15:0] frag_length;
      logic [15:0] frag_offset;
      logic        more_frags;
      logic [31:0] sent_sec;
   } entry_type;

   typedef struct packed {
      logic        operation;
      logic [15:0] frame_id;
      logic [31:0] packet_id;
      logic [15:0] frag_length;
      logic [15:0] frag_offset;
      logic        more_frags;
      logic        was_acked;
      logic [7:0]  retries;
      logic [31:0] now_sec;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] out_packet_id;
      logic [15:0] out_frag_length;
      logic [15:0] out_frag_offset;
      logic        out_more_frags;
      logic        out_acked;
      logic [7:0]  out_retries;
      logic [4:0]  entries_in_use;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE, S_SWEEP, S_SEARCH, S_SHIFT, S_APPEND, S_OUT
   } state_type;
endpackage

>>> src/ptst_if.sv
`timescale 1ns / 1ps
interface ptst_req_if;
   logic valid;
   logic ready;
   ptst_pkg::req_type data;
   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

interface ptst_rsp_if;
   logic valid;
   logic ready;
   ptst_pkg::rsp_type data;
   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

>>> src/pending_tx_status_table.sv
`timescale 1ns / 1ps
// Pending transmit status table.
// req: one item per transfer; operation record (0) stores a sent frame,
// operation status (1) looks up the oldest entry with the same frame id,
// reports and removes it. rsp: one result per request.
// The table is held in a register array, one entry visited per cycle by a
// single shared compare unit and walked under a small sequencer.
// Record: the sweep time is checked first, then, when a sweep runs, each
// valid entry is visited in turn (aged entries compacted in place), then
// the output step. Status: entries are visited up to and including the
// match, or all of them when nothing matches, then each entry behind it
// is moved up to close the gap, then the output step. req_ready is high
// only when idle, so a new item is taken only after the last one has
// passed its output step.
// The result waits in the rsp register until taken; the next item runs
// meanwhile and holds in its output cycle while the old result still waits.
// csr writes change age limit and sweep interval.
// Reset (synchronous, active high) empties the table at once, clears the
// last sweep time and restores both registers to 10 seconds.
module pending_tx_status_table (
   input  logic        clock,
   input  logic        reset,
   ptst_req_if.sink    req,
   ptst_rsp_if.source  rsp,
   input  logic        csr_write,
   input  logic [0:0]  csr_index,
   input  logic [7:0]  csr_data
);
   localparam int D = ptst_pkg::TableDepth;
   localparam int IW = ptst_pkg::IdxW;
   localparam int CW = ptst_pkg::CntW;

   ptst_pkg::entry_type tbl_ff [D];
   ptst_pkg::state_type state_ff, state_in;
   ptst_pkg::req_type   item_ff;
   ptst_pkg::rsp_type   rsp_ff, res_ff, rsp_out;
   logic [CW-1:0] used_ff, rd_ff, wr_ff;
   logic [31:0]   last_ff;
   logic [7:0]    age_ff, intv_ff;
   logic          rsp_valid_ff;

   ptst_pkg::entry_type cur, nxt;
   logic [32:0] lim;
   logic        aged, hit, at_end, sweep_due, out_free, tbl_full;

   always_comb begin
      cur = tbl_ff[rd_ff[IW-1:0]];
      nxt = tbl_ff[(rd_ff[IW-1:0] + 1'b1)];
      // shared compare unit
      lim = (state_ff == ptst_pkg::S_APPEND) ?
            {1'b0, last_ff} + {25'd0, intv_ff} : {1'b0, cur.sent_sec} + {25'd0, age_ff};
      aged = {1'b0, item_ff.now_sec} > lim;
      sweep_due = aged;
      hit = cur.frame_id == item_ff.frame_id;
      at_end = rd_ff >= used_ff;
      out_free = !rsp_valid_ff || rsp.ready;
      tbl_full = used_ff >= CW'(D);
   end

   always_comb begin
      rsp_out = res_ff;
      if (item_ff.operation == ptst_pkg::OpRecord) begin
         rsp_out.status = tbl_full ? ptst_pkg::StFull : ptst_pkg::StStored;
         rsp_out.entries_in_use = 5'(tbl_full ? used_ff : used_ff + 1'b1);
      end else begin
         if (res_ff.status != ptst_pkg::StFound)
            rsp_out.status = ptst_pkg::StNotFound;
         rsp_out.entries_in_use = 5'(used_ff);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ptst_pkg::S_IDLE:
            if (req.valid && req.ready)
               state_in = (req.data.operation == ptst_pkg::OpRecord) ?
                          ptst_pkg::S_APPEND : ptst_pkg::S_SEARCH;
         ptst_pkg::S_APPEND:
            if (sweep_due && used_ff != '0) state_in = ptst_pkg::S_SWEEP;
            else state_in = ptst_pkg::S_OUT;
         ptst_pkg::S_SWEEP:
            if (rd_ff + 1'b1 >= used_ff) state_in = ptst_pkg::S_OUT;
         ptst_pkg::S_SEARCH:
            if (at_end) state_in = ptst_pkg::S_OUT;
            else if (hit) state_in = ptst_pkg::S_SHIFT;
         ptst_pkg::S_SHIFT:
            if (rd_ff + 1'b1 >= used_ff) state_in = ptst_pkg::S_OUT;
         ptst_pkg::S_OUT:
            if (out_free) state_in = ptst_pkg::S_IDLE;
         default: state_in = ptst_pkg::S_IDLE;
      endcase
   end

   assign req.ready = (state_ff == ptst_pkg::S_IDLE);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data = rsp_ff;

   // Note: S_APPEND here is the sweep check for records; the actual append
   // happens in S_OUT after any sweep.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptst_pkg::S_IDLE;
         used_ff <= '0;
         last_ff <= '0;
         age_ff <= ptst_pkg::AgeLimitReset;
         intv_ff <= ptst_pkg::SweepIntervalReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write) begin
            if (csr_index == ptst_pkg::CsrAgeLimit) age_ff <= csr_data;
            if (csr_index == ptst_pkg::CsrSweepInterval) intv_ff <= csr_data;
         end
         if (state_ff == ptst_pkg::S_OUT && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp.valid && rsp.ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ptst_pkg::S_IDLE:
               if (req.valid && req.ready) begin
                  item_ff <= req.data;
                  rd_ff <= '0;
                  wr_ff <= '0;
                  res_ff <= '0;
               end
            ptst_pkg::S_APPEND:
               if (sweep_due) begin
                  last_ff <= item_ff.now_sec;
                  if (used_ff == '0) used_ff <= '0;
               end
            ptst_pkg::S_SWEEP: begin
               // keep young entries, compact toward the head
               if (!aged) begin
                  tbl_ff[wr_ff[IW-1:0]] <= cur;
                  wr_ff <= wr_ff + 1'b1;
               end
               rd_ff <= rd_ff + 1'b1;
               if (rd_ff + 1'b1 >= used_ff)
                  used_ff <= aged ? wr_ff : wr_ff + 1'b1;
            end
            ptst_pkg::S_SEARCH:
               if (!at_end) begin
                  if (hit) begin
                     res_ff.status <= ptst_pkg::StFound;
                     res_ff.out_packet_id <= cur.packet_id;
                     res_ff.out_frag_length <= cur.frag_length;
                     res_ff.out_frag_offset <= cur.frag_offset;
                     res_ff.out_more_frags <= cur.more_frags;
                     res_ff.out_acked <= item_ff.was_acked;
                     res_ff.out_retries <= item_ff.retries;
                  end else rd_ff <= rd_ff + 1'b1;
               end
            ptst_pkg::S_SHIFT: begin
               if (rd_ff + 1'b1 < used_ff) tbl_ff[rd_ff[IW-1:0]] <= nxt;
               rd_ff <= rd_ff + 1'b1;
               if (rd_ff + 1'b1 >= used_ff) used_ff <= used_ff - 1'b1;
            end
            ptst_pkg::S_OUT:
               // hold until the previous result has left the rsp register
               if (out_free) begin
                  rsp_ff <= rsp_out;
                  if (item_ff.operation == ptst_pkg::OpRecord && !tbl_full) begin
                     tbl_ff[used_ff[IW-1:0]] <= '{item_ff.frame_id, item_ff.packet_id,
                        item_ff.frag_length, item_ff.frag_offset, item_ff.more_frags,
                        item_ff.now_sec};
                     used_ff <= used_ff + 1'b1;
                  end
               end
            default: ;
         endcase
      end
   end

   a_count: assert property (@(posedge clock) disable iff (reset) used_ff <= CW'(D))
      else $error("entry count beyond depth");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ptst_pkg::S_IDLE |-> !req.ready)
      else $error("ready while busy");
   a_out: assert property (@(posedge clock) disable iff (reset)
      state_ff == ptst_pkg::S_OUT |=> rsp_valid_ff)
      else $error("result not presented");
endmodule

>>> tb/sv/pending_tx_status_table_tb.sv
`timescale 1ns / 1ps
module pending_tx_status_table_tb;
   logic       clock;
   logic       reset;
   logic       csr_write;
   logic [0:0] csr_index;
   logic [7:0] csr_data;

   ptst_req_if req_ch();
   ptst_rsp_if rsp_ch();

   pending_tx_status_table dut (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   // predictor copy of the table
   ptst_pkg::entry_type tbl [ptst_pkg::TableDepth];
   int         tbl_used;
   logic [31:0] last_sweep;
   logic [7:0] age_limit;
   logic [7:0] sweep_gap;

   ptst_pkg::rsp_type pending_rsp[$];
   int         errors;
   bit         quiet;
   logic [31:0] clock_sec;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("pending_tx_status_table test failed");
      $finish;
   end

   function automatic void drop_slot(int idx);
      for (int i = idx; i + 1 < tbl_used; i++) tbl[i] = tbl[i + 1];
      tbl_used--;
   endfunction

   function automatic ptst_pkg::rsp_type predict_table(ptst_pkg::req_type r);
      ptst_pkg::rsp_type o;
      int wr;
      o = '0;
      if (r.operation == ptst_pkg::OpRecord) begin
         if ({1'b0, r.now_sec} > {1'b0, last_sweep} + 33'(sweep_gap)) begin
            wr = 0;
            for (int rd = 0; rd < tbl_used; rd++) begin
               if ({1'b0, r.now_sec} > {1'b0, tbl[rd].sent_sec} + 33'(age_limit))
                  continue;
               tbl[wr] = tbl[rd];
               wr++;
            end
            tbl_used = wr;
            last_sweep = r.now_sec;
         end
         if (tbl_used >= ptst_pkg::TableDepth) o.status = ptst_pkg::StFull;
         else begin
            tbl[tbl_used] = '{r.frame_id, r.packet_id, r.frag_length, r.frag_offset,
                              r.more_frags, r.now_sec};
            tbl_used++;
            o.status = ptst_pkg::StStored;
         end
      end else begin
         o.status = ptst_pkg::StNotFound;
         for (int i = 0; i < tbl_used; i++) begin
            if (tbl[i].frame_id == r.frame_id) begin
               o.status = ptst_pkg::StFound;
               o.out_packet_id = tbl[i].packet_id;
               o.out_frag_length = tbl[i].frag_length;
               o.out_frag_offset = tbl[i].frag_offset;
               o.out_more_frags = tbl[i].more_frags;
               o.out_acked = r.was_acked;
               o.out_retries = r.retries;
               drop_slot(i);
               break;
            end
         end
      end
      o.entries_in_use = 5'(tbl_used);
      return o;
   endfunction

   function automatic bit idle_now();
      return !quiet && ($urandom_range(99) < 17);
   endfunction

   task automatic send_item(ptst_pkg::req_type r);
      // step off the edge that dropped valid for the previous transfer
      @(posedge clock);
      while (idle_now()) @(posedge clock);
      pending_rsp.push_back(predict_table(r));
      req_ch.valid <= 1'b1;
      req_ch.data <= r;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      req_ch.valid <= 1'b0;
   endtask

   task automatic drain();
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(logic [0:0] idx, logic [7:0] val);
      drain();
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == ptst_pkg::CsrAgeLimit) age_limit = val;
      else sweep_gap = val;
   endtask

   function automatic ptst_pkg::req_type make_item(logic op, logic [15:0] fid,
                                                   logic [31:0] now);
      ptst_pkg::req_type r;
      r.operation = op;
      r.frame_id = fid;
      r.packet_id = $urandom;
      r.frag_length = 16'($urandom);
      r.frag_offset = 16'($urandom);
      r.more_frags = 1'($urandom);
      r.was_acked = 1'($urandom);
      r.retries = 8'($urandom);
      r.now_sec = now;
      return r;
   endfunction

   // compare every result transfer against the oldest prediction
   always @(posedge clock) begin
      ptst_pkg::rsp_type e, a;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         a = rsp_ch.data;
         if (pending_rsp.size() == 0) begin
            $error("result with nothing expected");
            errors++;
         end else begin
            e = pending_rsp.pop_front();
            if (a.status !== e.status) begin
               $error("status exp %0d got %0d", e.status, a.status); errors++;
            end
            if (a.out_packet_id !== e.out_packet_id) begin
               $error("out_packet_id exp %0h got %0h", e.out_packet_id, a.out_packet_id);
               errors++;
            end
            if (a.out_frag_length !== e.out_frag_length) begin
               $error("out_frag_length exp %0h got %0h", e.out_frag_length,
                      a.out_frag_length); errors++;
            end
            if (a.out_frag_offset !== e.out_frag_offset) begin
               $error("out_frag_offset exp %0h got %0h", e.out_frag_offset,
                      a.out_frag_offset); errors++;
            end
            if (a.out_more_frags !== e.out_more_frags) begin
               $error("out_more_frags exp %0b got %0b", e.out_more_frags, a.out_more_frags);
               errors++;
            end
            if (a.out_acked !== e.out_acked) begin
               $error("out_acked exp %0b got %0b", e.out_acked, a.out_acked); errors++;
            end
            if (a.out_retries !== e.out_retries) begin
               $error("out_retries exp %0h got %0h", e.out_retries, a.out_retries); errors++;
            end
            if (a.entries_in_use !== e.entries_in_use) begin
               $error("entries_in_use exp %0d got %0d", e.entries_in_use, a.entries_in_use);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) rsp_ch.ready <= idle_now() ? 1'b0 : 1'b1;

   task automatic test_directed();
      ptst_pkg::req_type r;
      // fill past full with duplicate ids at time zero
      for (int i = 0; i < 17; i++)
         send_item(make_item(ptst_pkg::OpRecord, (i < 3) ? 16'hFFFF : 16'(i), 32'd0));
      // duplicates: oldest first
      send_item(make_item(ptst_pkg::OpStatus, 16'hFFFF, 32'd0));
      send_item(make_item(ptst_pkg::OpStatus, 16'hFFFF, 32'd0));
      send_item(make_item(ptst_pkg::OpStatus, 16'h0000, 32'd0));
      // status never sweeps, even far in the future
      send_item(make_item(ptst_pkg::OpStatus, 16'd5, 32'hFFFF_FFFF));
      r = make_item(ptst_pkg::OpRecord, 16'd0, 32'hFFFF_FFFF);
      r.packet_id = '1; r.frag_length = '1; r.frag_offset = '1; r.more_frags = 1'b1;
      send_item(r);
      r = make_item(ptst_pkg::OpStatus, 16'd0, 32'hFFFF_FFFF);
      r.was_acked = 1'b1; r.retries = '1;
      send_item(r);
      send_item(make_item(ptst_pkg::OpStatus, 16'd0, 32'hFFFF_FFFF));
   endtask

   // records and status at random, ids often from entries still held, small id space for hits
   task automatic test_random(int count);
      logic [15:0] fid;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(9) < 2) clock_sec += $urandom_range(3);
         if ($urandom_range(99) == 0) clock_sec = $urandom;
         if ($urandom_range(3) == 0) fid = 16'($urandom);
         else if (tbl_used > 0 && $urandom_range(1))
            fid = tbl[$urandom_range(tbl_used - 1)].frame_id;
         else fid = 16'($urandom_range(7));
         send_item(make_item(1'($urandom_range(1)), fid, clock_sec));
      end
   endtask

   initial begin
      errors = 0;
      quiet = 1'b0;
      tbl_used = 0;
      last_sweep = '0;
      age_limit = ptst_pkg::AgeLimitReset;
      sweep_gap = ptst_pkg::SweepIntervalReset;
      clock_sec = 32'd100;
      reset = 1'b1;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data = '0;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random(250);
      write_csr(ptst_pkg::CsrAgeLimit, 8'd0);
      write_csr(ptst_pkg::CsrSweepInterval, 8'd0);
      test_random(200);
      write_csr(ptst_pkg::CsrAgeLimit, 8'hFF);
      write_csr(ptst_pkg::CsrSweepInterval, 8'hFF);
      quiet = 1'b1;
      test_random(200);
      quiet = 1'b0;
      write_csr(ptst_pkg::CsrAgeLimit, 8'd3);
      write_csr(ptst_pkg::CsrSweepInterval, 8'd1);
      test_random(250);
      write_csr(ptst_pkg::CsrAgeLimit, 8'($urandom));
      write_csr(ptst_pkg::CsrSweepInterval, 8'($urandom_range(5)));
      test_random(230);
      drain();

      if (errors == 0 && pending_rsp.size() == 0)
         $display("pending_tx_status_table test passed");
      else
         $display("pending_tx_status_table test failed");
      $finish;
   end
endmodule
